>>> hw/rtl/ffca_pkg.sv
// ----------------------------------------------------------------------------
// ffca_pkg
// shared types and constants of the first-fit coalescing allocator
// ----------------------------------------------------------------------------
package ffca_pkg;

  // default parameter values
  localparam int unsigned MaxExtentsDef  = 16;
  localparam int unsigned HeaderBytesDef = 16;
  localparam int unsigned AddrBitsDef    = 32;

  // action codes
  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_INIT  = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_BYTES = 2'd1;
  localparam logic [1:0] REG_OVH   = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] request_bytes;
    logic [2:0]  align_log2;
    logic [31:0] address;
    logic [31:0] block_bytes;
    logic [7:0]  block_adjust;
  } ffca_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_address;
    logic [31:0] granted_bytes;
    logic [7:0]  granted_adjust;
    logic [31:0] used_bytes;
    logic [31:0] live_count;
  } ffca_rsp_t;

endpackage

>>> hw/rtl/ffca_ram.sv
// ----------------------------------------------------------------------------
// ffca_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ffca_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> hw/rtl/first_fit_coalescing_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator_top
// first-fit free-extent allocator with merging of neighbor extents on free
// ----------------------------------------------------------------------------
// usage:
//   a command transfer is taken when start is high and busy is low; busy
//   then stays high until the command is done. the result is on rsp_o for
//   exactly one cycle, marked by rsp_valid_o; the receiver cannot stall it.
//   a new command may be issued in the cycle the result is shown.
//   the apb port writes region_base (0x0), region_bytes (0x4) and
//   overhead_bytes (0x8); write it only while busy is low.
// what each command does while busy is high (the strobe comes in the cycle
// after), using the one shared adder and the extent ram with registered read:
//   no operation: nothing; initialize: writes the one region extent
//   allocate : examines extents in order, then splits the first that fits,
//              or shifts entries down when it is used up whole; fails if none fits
//   free     : scans extents, then merges with one neighbor, or merges with
//              both and shifts entries down, or inserts and shifts entries up;
//              reports full when the table has no room to insert
// reset: the extent table is empty until an initialize command; the
// counters reset to used 64, live 0. the table ram needs no clearing.
// ----------------------------------------------------------------------------
module first_fit_coalescing_allocator_top #(
  parameter int unsigned MAX_EXTENTS  = ffca_pkg::MaxExtentsDef,
  parameter int unsigned HEADER_BYTES = ffca_pkg::HeaderBytesDef,
  parameter int unsigned ADDR_BITS    = ffca_pkg::AddrBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command channel
  input  logic               start,
  output logic               busy,
  input  ffca_pkg::ffca_req_t req_i,
  // result channel
  output logic               rsp_valid_o,
  output ffca_pkg::ffca_rsp_t rsp_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ffca_pkg::*;

  localparam int unsigned AW = ADDR_BITS;
  localparam int unsigned IW = $clog2(MAX_EXTENTS);
  localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned WA = (AW > 33) ? AW : 33;   // shared adder width
  localparam int unsigned EW = AW + 32;               // table entry {start, size}

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_FIN, S_FAIL,
    S_A_RD, S_A_ADJ, S_A_TOT, S_A_CMP, S_A_SPL, S_A_ADR, S_A_USE,
    S_F_BS, S_F_BE, S_F_RD, S_F_CHK, S_F_DEC, S_F_DEC2, S_F_SAT2, S_F_CNT,
    S_I_RD, S_I_WR, S_R_CHK, S_R_WR
  } state_e;

  state_e state_q;

  // configuration registers
  logic [31:0] region_base_q, region_bytes_q;
  logic [11:0] overhead_q;

  // latched command
  logic [1:0]    act_q;
  logic [31:0]   req_bytes_q;
  logic [2:0]    align_q;
  logic [AW-1:0] addr_q;
  logic [31:0]   bsize_q;
  logic [7:0]    badj_q;

  // working registers
  logic [CW-1:0] idx_q, jdx_q, count_q;
  logic [AW-1:0] cur_s_q, prev_s_q, bstart_q, bend_q;
  logic [31:0]   cur_z_q, prev_z_q, tmp_q;
  logic [7:0]    adj_q;
  logic [32:0]   tot_q, diff_q;
  logic          mprev_q;
  logic [31:0]   used_q, live_q;

  // result registers
  logic          valid_q;
  logic [1:0]    res_status_q;
  logic [31:0]   res_addr_q, res_bytes_q;
  logic [7:0]    res_adj_q;

  // ram
  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic [AW-1:0] rd_start;
  logic [31:0]   rd_size;

  ffca_ram #(.Width(EW), .Depth(MAX_EXTENTS)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_start = ram_rdata[EW-1:32];
  assign rd_size  = ram_rdata[31:0];

  // shared adder / subtractor
  logic [WA-1:0] add_a, add_x, add_b;
  logic          add_sub;
  logic [WA:0]   add_sum;
  logic          carry;
  logic [31:0]   sat_sum;

  assign add_b   = add_sub ? ~add_x : add_x;
  assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{WA{1'b0}}, add_sub};
  assign carry   = add_sum[WA];            // on subtract: no borrow
  assign sat_sum = add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];

  logic mnext_c, accept, cfg_we;
  logic [6:0] base_lo, amask;

  assign accept  = start && !busy;
  assign busy    = (state_q != S_IDLE);
  assign mnext_c = (idx_q < count_q) && (cur_s_q == bend_q);
  assign cfg_we  = psel && penable && pwrite;
  assign pready  = 1'b1;

  // alignment adjustment from the low bits of the extent start
  assign base_lo = rd_start[6:0] + 7'(HEADER_BYTES);
  assign amask   = 7'((8'd1 << align_q) - 8'd1);

  always_comb begin
    add_a   = '0;
    add_x   = '0;
    add_sub = 1'b0;
    case (state_q)
      S_A_TOT:  begin add_a = WA'(req_bytes_q); add_x = WA'(adj_q); end
      S_A_CMP:  begin add_a = WA'(cur_z_q); add_x = WA'(tot_q); add_sub = 1'b1; end
      S_A_SPL:  begin add_a = WA'(cur_s_q); add_x = WA'(tot_q); end
      S_A_ADR:  begin add_a = WA'(cur_s_q); add_x = WA'(adj_q); end
      S_A_USE:  begin add_a = WA'(used_q); add_x = WA'(tot_q); end
      S_F_BS:   begin add_a = WA'(addr_q); add_x = WA'(badj_q); add_sub = 1'b1; end
      S_F_BE:   begin add_a = WA'(bstart_q); add_x = WA'(bsize_q); end
      S_F_CHK:  begin add_a = WA'(rd_start); add_x = WA'(bend_q); add_sub = 1'b1; end
      S_F_DEC:  begin add_a = WA'(prev_s_q); add_x = WA'(prev_z_q); end
      S_F_DEC2: begin
        add_a = mprev_q ? WA'(prev_z_q) : WA'(cur_z_q);
        add_x = WA'(bsize_q);
      end
      S_F_SAT2: begin add_a = WA'(tmp_q); add_x = WA'(cur_z_q); end
      S_F_CNT:  begin add_a = WA'(used_q); add_x = WA'(bsize_q); add_sub = 1'b1; end
      default:  ;
    endcase
  end

  // table port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q[IW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx_q[IW-1:0];
    case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {AW'(region_base_q), region_bytes_q};
      end
      S_A_SPL: begin
        ram_we    = 1'b1;
        ram_wdata = {add_sum[AW-1:0], diff_q[31:0]};
      end
      S_F_DEC2: begin
        if (mprev_q && !mnext_c) begin
          ram_we    = 1'b1;
          ram_waddr = IW'(idx_q - 1'b1);
          ram_wdata = {prev_s_q, sat_sum};
        end else if (!mprev_q && mnext_c) begin
          ram_we    = 1'b1;
          ram_wdata = {bstart_q, sat_sum};
        end
      end
      S_F_SAT2: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(idx_q - 1'b1);
        ram_wdata = {prev_s_q, sat_sum};
      end
      S_I_RD: begin
        ram_raddr = IW'(jdx_q - 1'b1);
        if (jdx_q == idx_q) begin
          ram_we    = 1'b1;
          ram_wdata = {bstart_q, bsize_q};
        end
      end
      S_I_WR: begin
        ram_we    = 1'b1;
        ram_waddr = jdx_q[IW-1:0];
      end
      S_R_CHK: ram_raddr = IW'(idx_q + 1'b1);
      S_R_WR:  ram_we    = 1'b1;
      default: ;
    endcase
  end

  // configuration read back
  always_comb begin
    case (paddr[3:2])
      REG_BASE:  prdata = region_base_q;
      REG_BYTES: prdata = region_bytes_q;
      REG_OVH:   prdata = {20'd0, overhead_q};
      default:   prdata = '0;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      region_base_q  <= '0;
      region_bytes_q <= 32'd65536;
      overhead_q     <= 12'd64;
      act_q          <= ACT_NOP;
      req_bytes_q    <= '0;
      align_q        <= '0;
      addr_q         <= '0;
      bsize_q        <= '0;
      badj_q         <= '0;
      idx_q          <= '0;
      jdx_q          <= '0;
      count_q        <= '0;
      cur_s_q        <= '0;
      prev_s_q       <= '0;
      bstart_q       <= '0;
      bend_q         <= '0;
      cur_z_q        <= '0;
      prev_z_q       <= '0;
      tmp_q          <= '0;
      adj_q          <= '0;
      tot_q          <= '0;
      diff_q         <= '0;
      mprev_q        <= 1'b0;
      used_q         <= 32'd64;
      live_q         <= '0;
      valid_q        <= 1'b0;
      res_status_q   <= ST_OK;
      res_addr_q     <= '0;
      res_bytes_q    <= '0;
      res_adj_q      <= '0;
    end else begin
      valid_q <= 1'b0;
      if (cfg_we) begin
        case (paddr[3:2])
          REG_BASE:  region_base_q  <= pwdata;
          REG_BYTES: region_bytes_q <= pwdata;
          REG_OVH:   overhead_q     <= pwdata[11:0];
          default:   ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            act_q        <= req_i.action;
            req_bytes_q  <= req_i.request_bytes;
            align_q      <= req_i.align_log2;
            addr_q       <= AW'(req_i.address);
            bsize_q      <= req_i.block_bytes;
            badj_q       <= req_i.block_adjust;
            res_status_q <= ST_OK;
            res_addr_q   <= '0;
            res_bytes_q  <= '0;
            res_adj_q    <= '0;
            idx_q        <= '0;
            case (req_i.action)
              ACT_ALLOC: state_q <= (count_q == '0) ? S_FAIL : S_A_RD;
              ACT_FREE:  state_q <= S_F_BS;
              ACT_INIT:  state_q <= S_INIT;
              default:   state_q <= S_FIN;
            endcase
          end
        end
        S_INIT: begin
          count_q <= CW'(1);
          used_q  <= 32'(overhead_q);
          live_q  <= '0;
          state_q <= S_FIN;
        end
        S_FAIL: begin
          res_status_q <= ST_NOFIT;
          state_q      <= S_FIN;
        end
        S_FIN: begin
          valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        // ---- allocate: first-fit scan
        S_A_RD:  state_q <= S_A_ADJ;
        S_A_ADJ: begin
          cur_s_q <= rd_start;
          cur_z_q <= rd_size;
          adj_q   <= 8'(HEADER_BYTES) + {1'b0, (7'd0 - base_lo) & amask};
          state_q <= S_A_TOT;
        end
        S_A_TOT: begin
          tot_q   <= add_sum[32:0];
          state_q <= S_A_CMP;
        end
        S_A_CMP: begin
          diff_q <= add_sum[32:0];
          if (!carry) begin
            // extent too small: next one
            idx_q   <= idx_q + 1'b1;
            state_q <= (idx_q + 1'b1 == count_q) ? S_FAIL : S_A_RD;
          end else if (add_sum[32:0] <= 33'(HEADER_BYTES)) begin
            // leftover too small to keep: take the whole extent
            tot_q   <= {1'b0, cur_z_q};
            state_q <= S_R_CHK;
          end else begin
            state_q <= S_A_SPL;
          end
        end
        S_A_SPL: state_q <= S_A_ADR;
        S_A_ADR: begin
          res_addr_q <= 32'(add_sum[AW-1:0]);
          state_q    <= S_A_USE;
        end
        S_A_USE: begin
          used_q      <= add_sum[31:0];
          live_q      <= live_q + 32'd1;
          res_bytes_q <= tot_q[31:0];
          res_adj_q   <= adj_q;
          state_q     <= S_FIN;
        end
        // ---- free: locate insertion point and merge
        S_F_BS: begin
          bstart_q <= add_sum[AW-1:0];
          state_q  <= S_F_BE;
        end
        S_F_BE: begin
          bend_q  <= add_sum[AW-1:0];
          state_q <= (count_q == '0) ? S_F_DEC : S_F_RD;
        end
        S_F_RD:  state_q <= S_F_CHK;
        S_F_CHK: begin
          if (!carry) begin
            // extent starts below block end: keep it as lower neighbor
            prev_s_q <= rd_start;
            prev_z_q <= rd_size;
            idx_q    <= idx_q + 1'b1;
            state_q  <= (idx_q + 1'b1 == count_q) ? S_F_DEC : S_F_RD;
          end else begin
            cur_s_q <= rd_start;
            cur_z_q <= rd_size;
            state_q <= S_F_DEC;
          end
        end
        S_F_DEC: begin
          mprev_q <= (idx_q != '0) && (add_sum[AW-1:0] == bstart_q);
          state_q <= S_F_DEC2;
        end
        S_F_DEC2: begin
          if (mprev_q && mnext_c) begin
            tmp_q   <= sat_sum;
            state_q <= S_F_SAT2;
          end else if (mprev_q || mnext_c) begin
            state_q <= S_F_CNT;
          end else if (count_q >= CW'(MAX_EXTENTS)) begin
            res_status_q <= ST_FULL;
            state_q      <= S_FIN;
          end else begin
            jdx_q   <= count_q;
            state_q <= S_I_RD;
          end
        end
        S_F_SAT2: state_q <= S_R_CHK;
        S_F_CNT: begin
          used_q  <= add_sum[31:0];
          live_q  <= live_q - 32'd1;
          state_q <= S_FIN;
        end
        // ---- insert: shift entries up from the top
        S_I_RD: begin
          if (jdx_q == idx_q) begin
            count_q <= count_q + 1'b1;
            state_q <= S_F_CNT;
          end else begin
            state_q <= S_I_WR;
          end
        end
        S_I_WR: begin
          jdx_q   <= jdx_q - 1'b1;
          state_q <= S_I_RD;
        end
        // ---- remove: shift entries down over the hole
        S_R_CHK: begin
          if (idx_q + 1'b1 < count_q) begin
            state_q <= S_R_WR;
          end else begin
            count_q <= count_q - 1'b1;
            state_q <= (act_q == ACT_ALLOC) ? S_A_ADR : S_F_CNT;
          end
        end
        S_R_WR: begin
          idx_q   <= idx_q + 1'b1;
          state_q <= S_R_CHK;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_valid_o          = valid_q;
  assign rsp_o.status         = res_status_q;
  assign rsp_o.result_address = res_addr_q;
  assign rsp_o.granted_bytes  = res_bytes_q;
  assign rsp_o.granted_adjust = res_adj_q;
  assign rsp_o.used_bytes     = used_q;
  assign rsp_o.live_count     = live_q;

  // assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_EXTENTS))
    else $error("extent count above table depth");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("command transfer did not raise busy");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !busy && !$past(rsp_valid_o))
    else $error("result strobe while busy or longer than one cycle");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status == ST_FULL) |-> count_q == CW'(MAX_EXTENTS))
    else $error("table full reported with free entries");

  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_I_RD) |-> count_q < CW'(MAX_EXTENTS))
    else $error("insert started on a full table");

endmodule

>>> verif/tb_first_fit_coalescing_allocator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_fit_coalescing_allocator_top
// self-checking bench: drives allocate/free/init/nop commands, rewrites the
// apb registers between phases and checks every result against a predictor
// ----------------------------------------------------------------------------
module tb_first_fit_coalescing_allocator_top;
  import ffca_pkg::*;

  localparam int unsigned NExt = MaxExtentsDef;
  localparam int unsigned Hdr  = HeaderBytesDef;

  // allocator predictor plus queue of expected results
  class alloc_scoreboard;
    logic [31:0] base_r, bytes_r;
    logic [11:0] ovh_r;
    logic [31:0] ext_start [NExt];
    logic [31:0] ext_size [NExt];
    int unsigned ext_n;
    logic [31:0] used_r, live_r;
    ffca_rsp_t   pending [$];
    int unsigned errors;

    function new();
      base_r = 32'd0; bytes_r = 32'd65536; ovh_r = 12'd64;
      ext_n = 0; used_r = 32'd64; live_r = 32'd0; errors = 0;
    endfunction

    function void remove_at(int unsigned i);
      for (int unsigned k = i; k + 1 < ext_n; k++) begin
        ext_start[k] = ext_start[k+1];
        ext_size[k]  = ext_size[k+1];
      end
      ext_n--;
    endfunction

    function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // note an accepted command and predict its result
    function void note_command(ffca_req_t c);
      ffca_rsp_t r;
      logic [31:0] s, bse, adj, bstart, bend;
      logic [32:0] total;
      logic [7:0]  mask;
      int unsigned i;
      bit mprev, mnext, done;
      r = '0;
      case (c.action)
        ACT_ALLOC: begin
          r.status = ST_NOFIT;
          done = 0;
          mask = (8'd1 << c.align_log2) - 8'd1;
          for (i = 0; i < ext_n && !done; i++) begin
            s = ext_start[i];
            bse = s + Hdr;
            adj = Hdr + ((32'd0 - bse) & {24'd0, mask});
            total = {1'b0, c.request_bytes} + {1'b0, adj};
            if ({1'b0, ext_size[i]} >= total) begin
              done = 1;
              if ({1'b0, ext_size[i]} - total <= Hdr) begin
                total = {1'b0, ext_size[i]};
                remove_at(i);
              end else begin
                ext_start[i] = s + total[31:0];
                ext_size[i]  = ext_size[i] - total[31:0];
              end
              r.status = ST_OK;
              r.result_address = s + adj;
              r.granted_bytes  = total[31:0];
              r.granted_adjust = adj[7:0];
              used_r += total[31:0];
              live_r += 32'd1;
            end
          end
        end
        ACT_FREE: begin
          bstart = c.address - {24'd0, c.block_adjust};
          bend   = bstart + c.block_bytes;
          i = 0;
          while (i < ext_n && ext_start[i] < bend) i++;
          mprev = i > 0 && (ext_start[i-1] + ext_size[i-1]) == bstart;
          mnext = i < ext_n && ext_start[i] == bend;
          r.status = ST_OK;
          if (mprev && mnext) begin
            ext_size[i-1] = sat_add(sat_add(ext_size[i-1], c.block_bytes), ext_size[i]);
            remove_at(i);
          end else if (mprev) begin
            ext_size[i-1] = sat_add(ext_size[i-1], c.block_bytes);
          end else if (mnext) begin
            ext_start[i] = bstart;
            ext_size[i]  = sat_add(ext_size[i], c.block_bytes);
          end else if (ext_n >= NExt) begin
            r.status = ST_FULL;
          end else begin
            for (int unsigned k = ext_n; k > i; k--) begin
              ext_start[k] = ext_start[k-1];
              ext_size[k]  = ext_size[k-1];
            end
            ext_start[i] = bstart;
            ext_size[i]  = c.block_bytes;
            ext_n++;
          end
          if (r.status == ST_OK) begin
            live_r -= 32'd1;
            used_r -= c.block_bytes;
          end
        end
        ACT_INIT: begin
          ext_start[0] = base_r;
          ext_size[0]  = bytes_r;
          ext_n  = 1;
          used_r = {20'd0, ovh_r};
          live_r = 32'd0;
        end
        default: ;
      endcase
      r.used_bytes = used_r;
      r.live_count = live_r;
      pending.push_back(r);
    endfunction

    function void check_result(ffca_rsp_t a);
      ffca_rsp_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transfer %p", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, a.status); errors++;
      end
      if (a.result_address !== e.result_address) begin
        $error("result_address exp %h got %h", e.result_address, a.result_address);
        errors++;
      end
      if (a.granted_bytes !== e.granted_bytes) begin
        $error("granted_bytes exp %h got %h", e.granted_bytes, a.granted_bytes); errors++;
      end
      if (a.granted_adjust !== e.granted_adjust) begin
        $error("granted_adjust exp %h got %h", e.granted_adjust, a.granted_adjust);
        errors++;
      end
      if (a.used_bytes !== e.used_bytes) begin
        $error("used_bytes exp %h got %h", e.used_bytes, a.used_bytes); errors++;
      end
      if (a.live_count !== e.live_count) begin
        $error("live_count exp %h got %h", e.live_count, a.live_count); errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        start, busy;
  ffca_req_t   req_i;
  logic        rsp_valid_o;
  ffca_rsp_t   rsp_o;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;

  alloc_scoreboard sb;
  int unsigned idle_pct;   // sender gap odds per hundred
  // live allocations handed out, kept for well-formed frees
  ffca_rsp_t   held [$];

  first_fit_coalescing_allocator_top uut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .rsp_valid_o, .rsp_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: receiver cannot stall, so every strobe is a transfer
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o) begin
      sb.check_result(rsp_o);
      if (rsp_o.status == ST_OK && rsp_o.granted_bytes != 0 && rsp_o.live_count != 0
          && rsp_o.result_address != 0 && held.size() < 64)
        held.push_back(rsp_o);
    end
  end

  // apb write: setup then access, pready is always high, then the bus goes idle
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_BASE:  sb.base_r  = val;
      REG_BYTES: sb.bytes_r = val;
      default:   sb.ovh_r   = val[11:0];
    endcase
    @(posedge clk_i);
  endtask

  // one command transfer, with a random gap ahead of it; start stays high
  // after the transfer while busy blocks it, and drops on a gap or drain
  task automatic send(ffca_req_t c);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk_i);
    end
    start <= 1; req_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_command(c);
  endtask

  // wait until all results are in, then a quiet stretch before apb writes
  task automatic drain();
    int unsigned n;
    n = 0;
    start <= 0;
    while (sb.pending.size() != 0 && n < 100000) begin
      @(posedge clk_i); n++;
    end
    repeat (200) @(posedge clk_i);
  endtask

  function automatic ffca_req_t mk_alloc(logic [31:0] nbytes, logic [2:0] al);
    ffca_req_t c;
    c = '0;
    c.action = ACT_ALLOC; c.request_bytes = nbytes; c.align_log2 = al;
    c.address = $urandom; c.block_bytes = $urandom; c.block_adjust = 8'($urandom);
    return c;
  endfunction

  function automatic ffca_req_t mk_free(logic [31:0] a, logic [31:0] b, logic [7:0] j);
    ffca_req_t c;
    c = '0;
    c.action = ACT_FREE; c.address = a; c.block_bytes = b; c.block_adjust = j;
    c.request_bytes = $urandom; c.align_log2 = 3'($urandom);
    return c;
  endfunction

  function automatic ffca_req_t mk_op(logic [1:0] op);
    ffca_req_t c;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    c = raw[$bits(ffca_req_t)-1:0];
    c.action = op;
    return c;
  endfunction

  // random command mix, mostly alloc/free pairs of real blocks
  task automatic random_run(int unsigned n);
    ffca_rsp_t h;
    int unsigned k, sel;
    for (int unsigned it = 0; it < n; it++) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        send(mk_alloc($urandom_range(9) == 0 ? $urandom : $urandom_range(600),
                      3'($urandom)));
      end else if (sel < 85 && held.size() > 0) begin
        k = $urandom_range(held.size() - 1);
        h = held[k];
        held.delete(k);
        send(mk_free(h.result_address, h.granted_bytes, h.granted_adjust));
      end else if (sel < 93) begin
        send(mk_free($urandom, $urandom_range(3) == 0 ? $urandom : $urandom_range(300),
                     8'($urandom)));
      end else if (sel < 97) begin
        send(mk_op(ACT_NOP));
      end else begin
        held.delete();
        send(mk_op(ACT_INIT));
      end
    end
  endtask

  initial begin
    sb = new();
    rst_ni = 0; start = 0; req_i = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    idle_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: empty table, defaults, extremes, special cases
    send(mk_alloc(32'd16, 3'd0));           // no fit on empty table
    send(mk_op(ACT_NOP));
    send(mk_op(ACT_INIT));
    send(mk_alloc(32'd0, 3'd0));            // zero request
    send(mk_alloc(32'd1, 3'd7));
    send(mk_alloc(32'hFFFF_FFFF, 3'd5));    // far too large
    send(mk_alloc(32'd100, 3'd2));
    send(mk_free(32'd16, 32'd16, 8'd16));   // give back the first block
    send(mk_free(32'hFFFF_FFF0, 32'hFFFF_FFFF, 8'hFF)); // bogus, wraps the block end
    send(mk_free(32'd0, 32'd0, 8'd0));
    for (int unsigned j = 0; j < 18; j++)   // scattered frees fill the table
      send(mk_free(32'h1000_0000 + j * 32'h100, 32'd8, 8'd0));
    drain();

    // register extremes, then whole-extent take
    reg_write(REG_BASE, 32'hFFFF_FFC0);
    reg_write(REG_BYTES, 32'hFFFF_FFFF);
    reg_write(REG_OVH, 32'hFFF);
    send(mk_op(ACT_INIT));
    send(mk_alloc(32'd40, 3'd6));           // wraps the address
    send(mk_alloc(32'hFFFF_FF00, 3'd0));
    drain();
    reg_write(REG_BASE, 32'd0);
    reg_write(REG_BYTES, 32'd48);
    reg_write(REG_OVH, 32'd0);
    send(mk_op(ACT_INIT));
    send(mk_alloc(32'd20, 3'd0));           // leftover within header: whole extent
    send(mk_alloc(32'd0, 3'd0));
    drain();

    // random phases with varied settings and sender gaps
    for (int unsigned ph = 0; ph < 4; ph++) begin
      held.delete();
      reg_write(REG_BASE, (ph == 3) ? 32'hFFFF_0000 : $urandom & 32'hFFFF_FFF8);
      reg_write(REG_BYTES, (ph == 2) ? 32'd0 : $urandom_range(1024, 20000));
      reg_write(REG_OVH, $urandom_range(4095));
      idle_pct = (ph == 1 || ph == 3) ? 46 : (ph == 2 ? 6 : 0);
      send(mk_op(ACT_INIT));
      random_run(500);
      drain();
    end

    if (sb.pending.size() != 0) begin
      $error("%0d results never arrived", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("tb_first_fit_coalescing_allocator_top: done, clean");
    end else begin
      $display("tb_first_fit_coalescing_allocator_top: done, errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("tb_first_fit_coalescing_allocator_top: done, errors");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/ffca_pkg.sv
hw/rtl/ffca_ram.sv
hw/rtl/first_fit_coalescing_allocator_top.sv
verif/tb_first_fit_coalescing_allocator_top.sv
